>>> hw/rtl/kef_pkg.sv
// ============================================================================
// kef_pkg
// Shared types and constants of the key event FIFO with its action map:
// transaction payloads, mode codes, action masks and the fixed key map.
// ============================================================================
`default_nettype none

package kef_pkg;

    // Mode codes of an input transaction.
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_JOY   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam int ACT_W = 18;
    typedef logic [ACT_W-1:0] act_t;

    // One bit per action.
    localparam act_t ACT_FWD     = 18'h00001;
    localparam act_t ACT_BACK    = 18'h00002;
    localparam act_t ACT_TURNL   = 18'h00004;
    localparam act_t ACT_TURNR   = 18'h00008;
    localparam act_t ACT_STRAFEL = 18'h00010;
    localparam act_t ACT_STRAFER = 18'h00020;
    localparam act_t ACT_FIRE    = 18'h00040;
    localparam act_t ACT_USE     = 18'h00080;
    localparam act_t ACT_RUN     = 18'h00100;
    localparam act_t ACT_MAP     = 18'h00200;
    localparam act_t ACT_MENU    = 18'h00400;
    localparam act_t ACT_WEAPON1 = 18'h00800;
    localparam act_t ACT_WEAPON2 = 18'h01000;
    localparam act_t ACT_WEAPON3 = 18'h02000;
    localparam act_t ACT_WEAPON4 = 18'h04000;
    localparam act_t ACT_WEAPON5 = 18'h08000;
    localparam act_t ACT_WEAPON6 = 18'h10000;
    localparam act_t ACT_WEAPON7 = 18'h20000;

    // Scan codes that carry an action, and the action of each.
    localparam int NUM_MAPPED = 23;

    localparam logic [7:0] MAP_CODE [NUM_MAPPED] = '{
        8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'h01, 8'h0f, 8'h11, 8'h48, 8'h1f, 8'h50, 8'h4b,
        8'h4d, 8'h1e, 8'h33, 8'h20, 8'h34, 8'h1d, 8'h39,
        8'h2a, 8'h36
    };

    localparam act_t MAP_ACT [NUM_MAPPED] = '{
        ACT_WEAPON1, ACT_WEAPON2, ACT_WEAPON3, ACT_WEAPON4, ACT_WEAPON5,
        ACT_WEAPON6, ACT_WEAPON7,
        ACT_MENU, ACT_MAP, ACT_FWD, ACT_FWD, ACT_BACK, ACT_BACK, ACT_TURNL,
        ACT_TURNR, ACT_STRAFEL, ACT_STRAFEL, ACT_STRAFER, ACT_STRAFER,
        ACT_FIRE, ACT_USE, ACT_RUN, ACT_RUN
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key_code;
        logic       pressed;
        logic [7:0] joystick_in;
    } kef_in_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] event_sequence;
        logic [7:0]  event_code;
        logic        event_pressed;
        logic [4:0]  pending_count;
        logic [31:0] rejected_count;
        logic        key_held;
        logic [4:0]  joystick_state;
        act_t        keyboard_actions;
        act_t        joystick_actions;
        act_t        held_actions;
    } kef_out_t;

    // One stored event.
    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  code;
        logic        pressed;
    } kef_event_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } kef_cmd_t;

    // Action mask of a five-bit joystick snapshot.
    function automatic act_t joy_actions(input logic [4:0] joy);
        act_t acc;
        acc = '0;
        if (joy[0]) acc = acc | ACT_FWD;
        if (joy[1]) acc = acc | ACT_BACK;
        if (joy[2]) acc = acc | ACT_TURNL;
        if (joy[3]) acc = acc | ACT_TURNR;
        if (joy[4]) acc = acc | ACT_FIRE;
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kef_ctrl.sv
// ============================================================================
// kef_ctrl
// Controller: takes one transaction, commits it from the EXEC state once the
// output register is free, and tracks the output valid flag.
// ============================================================================
`default_nettype none

module kef_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output kef_pkg::kef_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Hold the item until the output register can take its result.
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/kef_datapath.sv
// ============================================================================
// kef_datapath
// Datapath: event ring and held-key memories, pointers, counters, joystick
// and mapped-key registers, action masks and the output register.
// ============================================================================
`default_nettype none

module kef_datapath #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kef_pkg::kef_cmd_t  cmd,
    input  wire kef_pkg::kef_in_t   in_data,
    output kef_pkg::kef_out_t       out_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam int KEYS = 256;

    // Memories: the event ring and the pressed bit of every scan code.
    kef_pkg::kef_event_t ring_mem [FIFO_DEPTH];
    logic                held_mem [KEYS];

    kef_pkg::kef_in_t    item_reg;
    kef_pkg::kef_event_t ring_rd_reg;
    logic                held_rd_reg;
    logic                held_hit_reg;
    logic [KEYS-1:0]     held_vld_reg;

    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]         seq_reg, seq_next;
    logic [31:0]         rej_reg, rej_next;
    logic [4:0]          joy_reg, joy_next;
    logic [kef_pkg::NUM_MAPPED-1:0] mapped_reg, mapped_next;

    kef_pkg::kef_out_t   out_reg, out_next;
    kef_pkg::kef_event_t wr_event;
    kef_pkg::act_t       kbd_act;
    kef_pkg::act_t       joy_act;
    logic                is_push, is_pop, is_joy, is_clear;
    logic                push_ok, pop_ok;
    logic                held_now;

    assign is_push  = (item_reg.mode == kef_pkg::MODE_PUSH);
    assign is_pop   = (item_reg.mode == kef_pkg::MODE_POP);
    assign is_joy   = (item_reg.mode == kef_pkg::MODE_JOY);
    assign is_clear = (item_reg.mode == kef_pkg::MODE_CLEAR);
    assign push_ok  = is_push && (cnt_reg != CNT_FULL);
    assign pop_ok   = is_pop && (cnt_reg != '0);

    assign wr_event.seq     = seq_reg;
    assign wr_event.code    = item_reg.key_code;
    assign wr_event.pressed = item_reg.pressed;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        seq_next    = seq_reg;
        rej_next    = rej_reg;
        joy_next    = joy_reg;
        mapped_next = mapped_reg;
        if (is_clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            cnt_next    = '0;
            seq_next    = '0;
            rej_next    = '0;
            joy_next    = '0;
            mapped_next = '0;
        end
        else if (is_push)
        begin
            if (push_ok)
            begin
                wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
                cnt_next    = cnt_reg + CNT_W'(1);
                seq_next    = seq_reg + 32'd1;
                for (int i = 0; i < kef_pkg::NUM_MAPPED; i++)
                begin
                    if (item_reg.key_code == kef_pkg::MAP_CODE[i])
                    begin
                        mapped_next[i] = item_reg.pressed;
                    end
                end
            end
            else
            begin
                rej_next = rej_reg + 32'd1;
            end
        end
        else if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            cnt_next    = cnt_reg - CNT_W'(1);
        end
        else if (is_joy)
        begin
            joy_next = item_reg.joystick_in[4:0];
        end
    end

    always_comb
    begin
        kbd_act = '0;
        for (int i = 0; i < kef_pkg::NUM_MAPPED; i++)
        begin
            if (mapped_next[i])
            begin
                kbd_act = kbd_act | kef_pkg::MAP_ACT[i];
            end
        end
    end

    assign joy_act = kef_pkg::joy_actions(joy_next);

    always_comb
    begin
        if (is_clear)
        begin
            held_now = 1'b0;
        end
        else if (push_ok)
        begin
            held_now = item_reg.pressed;
        end
        else
        begin
            held_now = held_hit_reg && held_rd_reg;
        end
    end

    always_comb
    begin
        out_next.accepted         = (is_push || is_pop) ? (push_ok || pop_ok) : 1'b1;
        out_next.event_sequence   = pop_ok ? ring_rd_reg.seq : 32'd0;
        out_next.event_code       = pop_ok ? ring_rd_reg.code : 8'd0;
        out_next.event_pressed    = pop_ok ? ring_rd_reg.pressed : 1'b0;
        out_next.pending_count    = 5'(cnt_next);
        out_next.rejected_count   = rej_next;
        out_next.key_held         = held_now;
        out_next.joystick_state   = joy_next;
        out_next.keyboard_actions = kbd_act;
        out_next.joystick_actions = joy_act;
        out_next.held_actions     = kbd_act | joy_act;
    end

    assign out_data = out_reg;

    // Memory ports: reads are taken when a transaction is captured, writes
    // land when it commits; the two never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ring_rd_reg <= ring_mem[rd_ptr_reg];
            held_rd_reg <= held_mem[in_data.key_code];
        end
        if (cmd.commit && push_ok)
        begin
            ring_mem[wr_ptr_reg]        <= wr_event;
            held_mem[item_reg.key_code] <= item_reg.pressed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            cnt_reg      <= '0;
            seq_reg      <= '0;
            rej_reg      <= '0;
            joy_reg      <= '0;
            mapped_reg   <= '0;
            held_vld_reg <= '0;
            held_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                held_hit_reg <= held_vld_reg[in_data.key_code];
            end
            if (cmd.commit)
            begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                cnt_reg    <= cnt_next;
                seq_reg    <= seq_next;
                rej_reg    <= rej_next;
                joy_reg    <= joy_next;
                mapped_reg <= mapped_next;
                if (is_clear)
                begin
                    held_vld_reg <= '0;
                end
                else if (push_ok)
                begin
                    held_vld_reg[item_reg.key_code] <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/key_event_fifo_with_action_map.sv
// A result is presented from the output register, loaded when the transaction commits.
// A new transaction is not taken before the last one commits; the held-key and
// event-ring memory reads are registered at capture and the update is committed in EXEC.
// A stalled output holds the item in its commit cycle until the result register frees.
// Reset (rst_n low, asynchronous) empties the FIFO, zeroes both counters, the
// joystick snapshot and all held keys; ring contents are left as they are.
// ============================================================================
// key_event_fifo_with_action_map
// Keyboard and joystick input controller: a scan-code event FIFO with
// sequence tags, a held-key map, a joystick snapshot and action masks.
// ============================================================================
`default_nettype none

module key_event_fifo_with_action_map #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire kef_pkg::kef_in_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output kef_pkg::kef_out_t       out_data
);

    // The controller and the datapath talk only through this command bundle.
    // A capture command latches the transaction and starts the memory reads;
    // a commit command applies the state update and loads the result register.
    kef_pkg::kef_cmd_t cmd;

    // The controller owns the handshake on both sides. Input is taken only
    // when no transaction is in flight, and the commit waits for the output
    // register to be empty or draining, so no result is ever overwritten.
    kef_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the event ring (written only by pushes that fit, so
    // a pop never reads an entry that was not written), the held-key memory
    // with one valid flag per scan code so that reset and clear take effect
    // at once, and a register copy of the keys that carry an action, which
    // drives the keyboard action mask without a sweep over the whole map.
    kef_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
